[design/fpfla_pkg.sv]
// ----------------------------------------------------------------------------
// fpfla_pkg
// Shared types and constants for the fixed-pool free-list allocator:
// command codes, active-count width and the controller state type.
// ----------------------------------------------------------------------------
package fpfla_pkg;

   // Command codes carried by an input item.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // The active count is a fixed 8-bit field that saturates at its top.
   localparam int unsigned COUNT_W = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   // Controller states.
   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FETCH
   } alc_state_type;

endpackage

[design/fixed_pool_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator
// Hands out and takes back fixed slots through a LIFO free list whose links
// live in a synchronous RAM. Each item gets exactly one result that carries
// the active count after the item.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/req_stall req_command, req_free_slot
//   rsp      out        rsp_valid/rsp_stall rsp_ok, rsp_slot_index,
//                                           rsp_active_count
//
// A free, a rejected free and an allocate on an empty pool load their result
// into the output register in the cycle they are taken. A granted allocate
// first passes through ST_FETCH: the link of the head slot is read from the
// link RAM, whose read data is registered. After reset a clearing pass
// (ST_SWEEP) writes the initial links; req_stall stays high during it.
// The result sits in an output register; a new item is taken while the held
// result is being taken, and req_stall rises while an unaccepted result waits.
// ----------------------------------------------------------------------------
module fixed_pool_free_list_allocator #(
   parameter int unsigned POOL_SLOTS = 255
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_command,
   input  logic [$clog2(POOL_SLOTS+1)-1:0]       req_free_slot,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_ok,
   output logic [$clog2(POOL_SLOTS+1)-1:0]       rsp_slot_index,
   output logic [fpfla_pkg::COUNT_W-1:0]         rsp_active_count
);

   import fpfla_pkg::*;

   // A slot number holds 0..POOL_SLOTS; the value POOL_SLOTS is the null link.
   localparam int unsigned SLOT_W = $clog2(POOL_SLOTS + 1);
   localparam int unsigned ADDR_W = $clog2(POOL_SLOTS);
   localparam logic [SLOT_W-1:0] NULL_LINK = SLOT_W'(POOL_SLOTS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_SLOTS - 1);

   alc_state_type state_ff, state_in;

   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_load;

   logic               out_free;
   logic               req_take;
   logic               pool_empty;
   logic               slot_in_range;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [SLOT_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [SLOT_W-1:0]  ram_rd_data;

   // Link store: one link per slot.
   fpfla_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (POOL_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // The output register can take a new result when empty or being drained.
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign req_stall     = (state_ff != ST_IDLE) || !out_free;
   assign req_take      = req_valid && !req_stall;
   assign pool_empty    = (head_ff >= NULL_LINK);
   assign slot_in_range = (req_free_slot < NULL_LINK);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && (req_command == CMD_ALLOC) && !pool_empty) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   // Datapath and memory control for each state.
   always_comb begin
      sweep_in     = sweep_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = sweep_ff;
      ram_wr_data  = SLOT_W'(sweep_ff) + SLOT_W'(1);
      ram_rd_en    = 1'b0;
      rsp_load     = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_slot_in  = '0;
      rsp_count_in = count_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            // Entry i links to i+1; the last entry gets POOL_SLOTS, the null link.
            ram_wr_en = 1'b1;
            sweep_in  = sweep_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_command == CMD_ALLOC) begin
                  if (pool_empty) begin
                     // Empty pool: report failure, no state change.
                     rsp_load = 1'b1;
                  end else begin
                     // Fetch the link of the head slot.
                     ram_rd_en = 1'b1;
                  end
               end else begin
                  if (slot_in_range) begin
                     // Push the slot onto the head of the list.
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = req_free_slot[ADDR_W-1:0];
                     ram_wr_data  = head_ff;
                     head_in      = req_free_slot;
                     if (count_ff != '0) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                     rsp_ok_in    = 1'b1;
                     rsp_slot_in  = req_free_slot;
                     rsp_count_in = count_in;
                  end
                  rsp_load = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            // Pop the head: follow its link and mark it detached.
            ram_wr_en    = 1'b1;
            ram_wr_addr  = head_ff[ADDR_W-1:0];
            ram_wr_data  = NULL_LINK;
            head_in      = ram_rd_data;
            if (count_ff < COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            rsp_load     = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_slot_in  = head_ff;
            rsp_count_in = count_in;
         end
         default: begin
            sweep_in = '0;
         end
      endcase
   end

   // Output valid: set on a new result, cleared when the result is taken.
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_active_count = rsp_count_ff;

endmodule

[design/fpfla_ram.sv]
// ----------------------------------------------------------------------------
// fpfla_ram
// Generic single-clock RAM with one write port and one read port.
// The read data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module fpfla_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 255
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
